// File: rtl/ppc_pkg.sv
`default_nettype none

package ppc_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int FIELD_W = 24;
  localparam int RAD_W = 16;
  localparam int ITEM_W = 8 * FIELD_W;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_CONTACT = 2'd1;
  localparam logic [1:0] ST_COINC   = 2'd2;

  // The root of D * 2^16 has 26 bits; every quotient here fits in 26 bits.
  localparam int SQ_STEPS  = 26;
  localparam int DIV_STEPS = 26;

  typedef struct packed {
    logic [ITEM_W-1:0]  v;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [24:0] rvx;
    logic signed [24:0] rvy;
    logic               near;
    logic [1:0]         status;
    logic [16:0]        mx;
    logic [16:0]        my;
    logic [33:0]        sqx;
    logic [33:0]        sqy;
    logic signed [42:0] dpx;
    logic signed [42:0] dpy;
    logic [34:0]        d2;
    logic signed [43:0] dot;
    logic               dotneg;
    logic [38:0]        pxlo;
    logic [38:0]        pxhi;
    logic [38:0]        pylo;
    logic [38:0]        pyhi;
    logic [61:0]        numx;
    logic [61:0]        numy;
    logic               sgnx;
    logic               sgny;
    logic [52:0]        sq_rem;
    logic [25:0]        root;
    logic [41:0]        ox;
    logic [41:0]        oy;
    logic [42:0]        remx;
    logic [42:0]        remy;
    logic [26:0]        denp;
    logic [25:0]        qpx;
    logic [25:0]        qpy;
    logic [25:0]        qvx;
    logic [25:0]        qvy;
  } pipe_t;

  function automatic logic [FIELD_W-1:0] sat24(input logic signed [27:0] x);
    if (x > 28'sd8388607) begin
      return 24'h7FFFFF;
    end else if (x < -28'sd8388608) begin
      return 24'h800000;
    end else begin
      return x[FIELD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/particle_pair_collision.sv
// Equal-mass circle pair contact response, one pair per word.
// Input stream: s_axis_tdata carries both circles (positions, velocities).
// Output stream: m_axis_tdata carries the corrected pair, m_axis_tuser the
// contact status (none, resolved, coincident centres skipped).
// The shared radius is written on the cfg channel, which is always ready;
// write it only while no pair is in flight.
// A new pair is accepted every cycle unless every stage holds a word and
// the receiver stalls; the depth comes from the 26-step square-root
// pipeline followed by the 26-step divider pipeline, one bit per stage.
// Each stage holds its word until the next stage frees, so when the
// receiver stalls the pipeline fills up bubbles first and s_axis_tready
// drops only once every stage holds a word. Nothing is lost or repeated.
// Reset clears all valid bits and sets the radius to 5.0.
`default_nettype none

module particle_pair_collision #(
  parameter int FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [ppc_pkg::RAD_W-1:0]    cfg_data_i,
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
  input  wire [ppc_pkg::ITEM_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
  // new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y
  output logic [ppc_pkg::ITEM_W-1:0]  m_axis_tdata,
  // contact_status
  output logic [1:0]                  m_axis_tuser
);

  localparam int  RESET_RAD_I = 5 << FRAC_BITS;
  localparam logic [ppc_pkg::RAD_W-1:0] RESET_RAD = RESET_RAD_I[ppc_pkg::RAD_W-1:0];
  localparam longint RESET_M  = 2 * longint'(RESET_RAD);
  localparam longint RESET_MM = RESET_M * RESET_M;
  localparam logic [33:0] RESET_MM_V = RESET_MM[33:0];

  localparam int ST_SQ0  = 6;
  localparam int ST_OV   = ST_SQ0 + ppc_pkg::SQ_STEPS;
  localparam int ST_DIV0 = ST_OV + 2;
  localparam int LAST    = ST_DIV0 + ppc_pkg::DIV_STEPS - 1;
  localparam int NST     = LAST + 1;

  logic [ppc_pkg::RAD_W-1:0] rad_q;
  logic [33:0]               mm_q;
  logic [16:0]               m_w;

  logic [NST:1]   vld_q;
  logic [NST:1]   ld;
  ppc_pkg::pipe_t st_q [1:LAST];
  ppc_pkg::pipe_t st_d [1:LAST];

  logic [ppc_pkg::ITEM_W-1:0] od_q;
  logic [1:0]                 ost_q;

  assign cfg_ready_o = 1'b1;
  assign m_w = {rad_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RESET_RAD;
      mm_q  <= RESET_MM_V;
    end else begin
      if (cfg_valid_i) begin
        rad_q <= cfg_data_i;
      end
      mm_q <= 34'(m_w) * 34'(m_w);
    end
  end

  // A stage may load when it is empty or its word moves on in this cycle.
  assign ld[NST] = !vld_q[NST] || m_axis_tready;
  for (genvar k = 1; k < NST; k++) begin : g_ld
    assign ld[k] = !vld_q[k] || ld[k+1];
  end
  assign s_axis_tready = ld[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[1]) begin
        vld_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_st
    if (k == 1) begin : g_diff
      logic signed [24:0] dx25, dy25;
      logic [24:0]        magx, magy;
      always_comb begin
        st_d[k] = '0;
        st_d[k].v = s_axis_tdata;
        dx25 = 25'($signed(s_axis_tdata[23:0])) - 25'($signed(s_axis_tdata[119:96]));
        dy25 = 25'($signed(s_axis_tdata[47:24])) - 25'($signed(s_axis_tdata[143:120]));
        st_d[k].rvx = 25'($signed(s_axis_tdata[71:48])) -
                      25'($signed(s_axis_tdata[167:144]));
        st_d[k].rvy = 25'($signed(s_axis_tdata[95:72])) -
                      25'($signed(s_axis_tdata[191:168]));
        magx = dx25[24] ? 25'(-dx25) : 25'(dx25);
        magy = dy25[24] ? 25'(-dy25) : 25'(dy25);
        st_d[k].near = (magx <= 25'(m_w)) && (magy <= 25'(m_w));
        st_d[k].dx = dx25[17:0];
        st_d[k].dy = dy25[17:0];
      end
    end else if (k == 2) begin : g_mul
      logic [17:0] ax, ay;
      always_comb begin
        st_d[k] = st_q[k-1];
        ax = st_q[k-1].dx[17] ? (18'd0 - st_q[k-1].dx) : st_q[k-1].dx;
        ay = st_q[k-1].dy[17] ? (18'd0 - st_q[k-1].dy) : st_q[k-1].dy;
        st_d[k].mx  = ax[16:0];
        st_d[k].my  = ay[16:0];
        st_d[k].sqx = 34'(ax[16:0]) * 34'(ax[16:0]);
        st_d[k].sqy = 34'(ay[16:0]) * 34'(ay[16:0]);
        st_d[k].dpx = 43'(st_q[k-1].dx) * 43'(st_q[k-1].rvx);
        st_d[k].dpy = 43'(st_q[k-1].dy) * 43'(st_q[k-1].rvy);
      end
    end else if (k == 3) begin : g_sum
      logic [34:0] d2;
      always_comb begin
        st_d[k] = st_q[k-1];
        d2 = 35'(st_q[k-1].sqx) + 35'(st_q[k-1].sqy);
        st_d[k].d2  = d2;
        st_d[k].dot = 44'(st_q[k-1].dpx) + 44'(st_q[k-1].dpy);
        if (!st_q[k-1].near || d2 > 35'(mm_q)) begin
          st_d[k].status = ppc_pkg::ST_NONE;
        end else if (d2 == '0) begin
          st_d[k].status = ppc_pkg::ST_COINC;
        end else begin
          st_d[k].status = ppc_pkg::ST_CONTACT;
        end
      end
    end else if (k == 4) begin : g_dvmul
      logic [43:0] dmag;
      always_comb begin
        st_d[k] = st_q[k-1];
        dmag = st_q[k-1].dot[43] ? (44'd0 - st_q[k-1].dot) : st_q[k-1].dot;
        st_d[k].dotneg = st_q[k-1].dot[43];
        st_d[k].pxlo = 39'(st_q[k-1].mx) * 39'(dmag[21:0]);
        st_d[k].pxhi = 39'(st_q[k-1].mx) * 39'(dmag[43:22]);
        st_d[k].pylo = 39'(st_q[k-1].my) * 39'(dmag[21:0]);
        st_d[k].pyhi = 39'(st_q[k-1].my) * 39'(dmag[43:22]);
      end
    end else if (k == 5) begin : g_dvnum
      always_comb begin
        st_d[k] = st_q[k-1];
        // Half the divisor is added up front for round to nearest.
        st_d[k].numx = (62'(st_q[k-1].pxhi) << 22) + 62'(st_q[k-1].pxlo) +
                       62'(st_q[k-1].d2 >> 1);
        st_d[k].numy = (62'(st_q[k-1].pyhi) << 22) + 62'(st_q[k-1].pylo) +
                       62'(st_q[k-1].d2 >> 1);
        st_d[k].sgnx = st_q[k-1].dx[17] ^ st_q[k-1].dotneg;
        st_d[k].sgny = st_q[k-1].dy[17] ^ st_q[k-1].dotneg;
        st_d[k].sq_rem = {2'b00, st_q[k-1].d2, 16'h0000};
        st_d[k].root = '0;
      end
    end else if (k < ST_OV) begin : g_sqrt
      localparam int BI = ppc_pkg::SQ_STEPS - 1 - (k - ST_SQ0);
      logic [52:0] trial;
      always_comb begin
        st_d[k] = st_q[k-1];
        trial = (53'(st_q[k-1].root) << (BI + 1)) + (53'(1) << (2 * BI));
        if (st_q[k-1].sq_rem >= trial) begin
          st_d[k].sq_rem = st_q[k-1].sq_rem - trial;
          st_d[k].root[BI] = 1'b1;
        end
      end
    end else if (k == ST_OV) begin : g_ov
      logic [25:0] ov;
      always_comb begin
        st_d[k] = st_q[k-1];
        ov = 26'({m_w, 8'h00}) - st_q[k-1].root;
        st_d[k].ox = 42'(st_q[k-1].mx) * 42'(ov[24:0]);
        st_d[k].oy = 42'(st_q[k-1].my) * 42'(ov[24:0]);
      end
    end else if (k == ST_OV + 1) begin : g_pnum
      always_comb begin
        st_d[k] = st_q[k-1];
        st_d[k].remx = 43'(st_q[k-1].ox) + 43'(st_q[k-1].root);
        st_d[k].remy = 43'(st_q[k-1].oy) + 43'(st_q[k-1].root);
        st_d[k].denp = {st_q[k-1].root, 1'b0};
        st_d[k].qpx = '0;
        st_d[k].qpy = '0;
        st_d[k].qvx = '0;
        st_d[k].qvy = '0;
      end
    end else begin : g_div
      localparam int BI = ppc_pkg::DIV_STEPS - 1 - (k - ST_DIV0);
      logic [51:0] cp;
      logic [61:0] cv;
      always_comb begin
        st_d[k] = st_q[k-1];
        cp = 52'(st_q[k-1].denp) << BI;
        cv = 62'(st_q[k-1].d2) << BI;
        if (52'(st_q[k-1].remx) >= cp) begin
          st_d[k].remx = st_q[k-1].remx - cp[42:0];
          st_d[k].qpx[BI] = 1'b1;
        end
        if (52'(st_q[k-1].remy) >= cp) begin
          st_d[k].remy = st_q[k-1].remy - cp[42:0];
          st_d[k].qpy[BI] = 1'b1;
        end
        if (st_q[k-1].numx >= cv) begin
          st_d[k].numx = st_q[k-1].numx - cv;
          st_d[k].qvx[BI] = 1'b1;
        end
        if (st_q[k-1].numy >= cv) begin
          st_d[k].numy = st_q[k-1].numy - cv;
          st_d[k].qvy[BI] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Output stage: apply signs, add, saturate.
  logic signed [26:0] psx, psy, dvx, dvy;
  logic signed [27:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
  logic [ppc_pkg::ITEM_W-1:0] od_d;

  always_comb begin
    psx = st_q[LAST].dx[17] ? -$signed({1'b0, st_q[LAST].qpx}) :
                               $signed({1'b0, st_q[LAST].qpx});
    psy = st_q[LAST].dy[17] ? -$signed({1'b0, st_q[LAST].qpy}) :
                               $signed({1'b0, st_q[LAST].qpy});
    dvx = st_q[LAST].sgnx ? -$signed({1'b0, st_q[LAST].qvx}) :
                             $signed({1'b0, st_q[LAST].qvx});
    dvy = st_q[LAST].sgny ? -$signed({1'b0, st_q[LAST].qvy}) :
                             $signed({1'b0, st_q[LAST].qvy});
    apx = 28'($signed(st_q[LAST].v[23:0]))    + 28'(psx);
    apy = 28'($signed(st_q[LAST].v[47:24]))   + 28'(psy);
    avx = 28'($signed(st_q[LAST].v[71:48]))   - 28'(dvx);
    avy = 28'($signed(st_q[LAST].v[95:72]))   - 28'(dvy);
    bpx = 28'($signed(st_q[LAST].v[119:96]))  - 28'(psx);
    bpy = 28'($signed(st_q[LAST].v[143:120])) - 28'(psy);
    bvx = 28'($signed(st_q[LAST].v[167:144])) + 28'(dvx);
    bvy = 28'($signed(st_q[LAST].v[191:168])) + 28'(dvy);
    if (st_q[LAST].status == ppc_pkg::ST_CONTACT) begin
      od_d = {ppc_pkg::sat24(bvy), ppc_pkg::sat24(bvx),
              ppc_pkg::sat24(bpy), ppc_pkg::sat24(bpx),
              ppc_pkg::sat24(avy), ppc_pkg::sat24(avx),
              ppc_pkg::sat24(apy), ppc_pkg::sat24(apx)};
    end else begin
      od_d = st_q[LAST].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[NST]) begin
      od_q  <= od_d;
      ost_q <= st_q[LAST].status;
    end
  end

  assign m_axis_tvalid = vld_q[NST];
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ost_q;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam int LATENCY = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int FW = ppc_pkg::FIELD_W;

  typedef struct packed {
    logic [ppc_pkg::ITEM_W-1:0] data;
    logic [1:0]                 status;
  } pair_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ppc_pkg::RAD_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
  logic [ppc_pkg::ITEM_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // new_a_pos_x .. new_b_vel_y, lowest first
  logic [ppc_pkg::ITEM_W-1:0] m_axis_tdata;
  // contact_status
  logic [1:0] m_axis_tuser;

  particle_pair_collision u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  logic [ppc_pkg::RAD_W-1:0] radius_q = 16'd1280;
  logic [ppc_pkg::ITEM_W-1:0] pair_q[$];
  pair_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_long = 1'b0;
  bit in_taken = 1'b0;

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [FW-1:0] clamp24(input longint x);
    if (x > 8388607) return 24'h7FFFFF;
    if (x < -8388608) return 24'h800000;
    return x[FW-1:0];
  endfunction

  function automatic pair_result_t resolve_pair(input logic [ppc_pkg::ITEM_W-1:0] d,
                                                input logic [ppc_pkg::RAD_W-1:0] rad);
    pair_result_t r;
    longint v[8];
    longint dx, dy, d2, m, s, ov, px, py, dot, dvx, dvy;
    for (int i = 0; i < 8; i++) v[i] = longint'($signed(d[i*FW +: FW]));
    r.data = d;
    dx = v[0] - v[4];
    dy = v[1] - v[5];
    d2 = dx * dx + dy * dy;
    m = 2 * longint'(rad);
    if (d2 > m * m) begin
      r.status = ppc_pkg::ST_NONE;
    end else if (d2 == 0) begin
      r.status = ppc_pkg::ST_COINC;
    end else begin
      s = longint'(isqrt(64'(d2 << 16)));
      ov = (m << 8) - s;
      px = round_div(dx * ov, 2 * s);
      py = round_div(dy * ov, 2 * s);
      dot = dx * (v[2] - v[6]) + dy * (v[3] - v[7]);
      dvx = round_div(dx * dot, d2);
      dvy = round_div(dy * dot, d2);
      r.data[0*FW +: FW] = clamp24(v[0] + px);
      r.data[1*FW +: FW] = clamp24(v[1] + py);
      r.data[2*FW +: FW] = clamp24(v[2] - dvx);
      r.data[3*FW +: FW] = clamp24(v[3] - dvy);
      r.data[4*FW +: FW] = clamp24(v[4] - px);
      r.data[5*FW +: FW] = clamp24(v[5] - py);
      r.data[6*FW +: FW] = clamp24(v[6] + dvx);
      r.data[7*FW +: FW] = clamp24(v[7] + dvy);
      r.status = ppc_pkg::ST_CONTACT;
    end
    return r;
  endfunction

  function automatic logic [ppc_pkg::ITEM_W-1:0] pack_pair(input logic [FW-1:0] f[8]);
    logic [ppc_pkg::ITEM_W-1:0] d;
    for (int i = 0; i < 8; i++) d[i*FW +: FW] = f[i];
    return d;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Pairs near contact for the current radius, content random otherwise.
  function automatic logic [ppc_pkg::ITEM_W-1:0] random_pair(
      input logic [ppc_pkg::RAD_W-1:0] rad);
    logic [FW-1:0] f[8];
    int span, kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) f[i] = FW'($urandom);
    span = 2 * int'(rad) + 4;
    if (kind < 7) begin
      f[0] = f[4] + FW'($urandom_range(0, 2 * span) - span);
      f[1] = f[5] + FW'($urandom_range(0, 2 * span) - span);
      if (kind < 4) begin
        for (int i = 0; i < 8; i++) begin
          if (i != 0 && i != 1 && i != 4 && i != 5) begin
            f[i] = FW'($urandom_range(0, 4095) - 2048);
          end
        end
        f[4] = FW'($urandom_range(0, 65535) - 32768);
        f[5] = FW'($urandom_range(0, 65535) - 32768);
        f[0] = f[4] + FW'($urandom_range(0, 2 * span) - span);
        f[1] = f[5] + FW'($urandom_range(0, 2 * span) - span);
      end
      if (kind == 0) begin
        f[0] = f[4];
        f[1] = f[5];
      end
    end
    return pack_pair(f);
  endfunction

  // Driver: one word pending on the input; gaps between words.
  int drv_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_taken) begin
        // The word was not taken at the last edge, so it stays.
      end else if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pair_q.size() > 0) begin
        s_axis_tdata <= pair_q.pop_front();
        s_axis_tvalid <= 1'b1;
        drv_gap <= gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Predict at acceptance.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      expected_q = {expected_q, resolve_pair(s_axis_tdata, radius_q)};
  end

  // Receiver backpressure.
  int rcv_gap = 0;
  always @(negedge clk_i) begin
    if (hold_long) begin
      m_axis_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap <= rcv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rcv_gap <= gap_len();
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    pair_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word data=%h status=%0d", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (m_axis_tdata[i*FW +: FW] !== exp_r.data[i*FW +: FW]) begin
            $display("%0t: field %0d expected %h actual %h", $time, i,
                     exp_r.data[i*FW +: FW], m_axis_tdata[i*FW +: FW]);
            errors++;
          end
        end
        if (m_axis_tuser !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("particle_pair_collision: mismatch");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pair_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [ppc_pkg::RAD_W-1:0] value);
    @(negedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    radius_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_pair(input int ax, ay, avx, avy, bx, by, bvx, bvy);
    logic [FW-1:0] f[8];
    f[0] = FW'(ax); f[1] = FW'(ay); f[2] = FW'(avx); f[3] = FW'(avy);
    f[4] = FW'(bx); f[5] = FW'(by); f[6] = FW'(bvx); f[7] = FW'(bvy);
    pair_q = {pair_q, pack_pair(f)};
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) pair_q = {pair_q, random_pair(radius_q)};
  endtask

  logic [ppc_pkg::RAD_W-1:0] radii[5] = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd20000};

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs at the reset radius of 5.0.
    add_pair(0, 0, 100, -50, 0, 0, 7, 9);
    add_pair(2560, 0, 256, 0, 0, 0, -256, 0);
    add_pair(2561, 0, 256, 0, 0, 0, -256, 0);
    add_pair(100, -200, 300, 40, -100, 50, -500, 20);
    add_pair(8388607, 8388607, 8388607, 8388607, 8388600, 8388600, -8388608, -8388608);
    add_pair(-8388608, -8388608, -8388608, 8388607, -8388600, -8388601, 8388607, -8388608);
    add_pair(8388607, 0, 0, 0, -8388608, 0, 0, 0);
    add_pair(1, 0, 0, 0, 0, 0, 0, 0);
    add_pair(0, -1, 5, 5, 0, 0, -5, -5);
    add_pair(-1810, 1810, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // Zero radius: coincident centres only.
    write_radius(16'd0);
    add_pair(0, 0, 1, 2, 0, 0, 3, 4);
    add_pair(1, 0, 1, 2, 0, 0, 3, 4);
    wait_drained();
    write_radius(16'd65535);
    add_pair(131070, 0, 10, 0, 0, 0, 0, 0);
    add_pair(8388607, 8388607, 8388607, -8388608, 8388000, 8388000, -8388608, 8388607);
    add_pair(-8388608, 0, 0, 0, -8388607, 0, 0, 0);
    random_phase(60);
    wait_drained();

    // Long receiver stall while the sender keeps offering.
    write_radius(16'd1280);
    random_phase(150);
    hold_long = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_long = 1'b0;
    wait_drained();

    foreach (radii[k]) begin
      write_radius(radii[k]);
      random_phase(120);
      wait_drained();
    end

    if (errors == 0) begin
      $display("particle_pair_collision: match");
    end else begin
      $display("particle_pair_collision: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire

// File: particle_pair_collision.f
rtl/ppc_pkg.sv
rtl/particle_pair_collision.sv
tb/sv/tb.sv
